[design/dslc_pkg.sv]
// Package for the dual sensor line crossing detector.
// Holds the widths, phase and mark codes, result type and the wait-window step.
// No dependencies.
package dslc_pkg;

    localparam int COUNT_WIDTH   = 16;
    localparam int WINDOW_WIDTH  = 16;
    localparam int CMP_WIDTH     = (COUNT_WIDTH > WINDOW_WIDTH) ? COUNT_WIDTH : WINDOW_WIDTH;
    localparam int PHASE_WIDTH   = 3;
    localparam int MARK_WIDTH    = 2;
    localparam int S_DATA_WIDTH  = 8;
    localparam int M_DATA_WIDTH  = 8;

    localparam logic [WINDOW_WIDTH-1:0] WINDOW_RESET = WINDOW_WIDTH'(20000);

    localparam logic [MARK_WIDTH-1:0] MARK_NONE   = 2'd0;
    localparam logic [MARK_WIDTH-1:0] MARK_FIRST  = 2'd1;
    localparam logic [MARK_WIDTH-1:0] MARK_SECOND = 2'd2;

    localparam logic [PHASE_WIDTH-1:0] PH_CODE_IDLE        = 3'd0;
    localparam logic [PHASE_WIDTH-1:0] PH_CODE_FIRST_WAIT  = 3'd1;
    localparam logic [PHASE_WIDTH-1:0] PH_CODE_WAIT_CLEAR  = 3'd2;
    localparam logic [PHASE_WIDTH-1:0] PH_CODE_ARMED       = 3'd3;
    localparam logic [PHASE_WIDTH-1:0] PH_CODE_SECOND_WAIT = 3'd4;
    localparam logic [PHASE_WIDTH-1:0] PH_CODE_DONE        = 3'd5;

    typedef enum logic [5:0] {
        PH_IDLE        = 6'b000001,
        PH_FIRST_WAIT  = 6'b000010,
        PH_WAIT_CLEAR  = 6'b000100,
        PH_ARMED       = 6'b001000,
        PH_SECOND_WAIT = 6'b010000,
        PH_DONE        = 6'b100000
    } phase_t;

    typedef struct packed {
        logic                   stop;
        logic [PHASE_WIDTH-1:0] phase;
    } result_t;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] count;
        logic                   done;
        logic                   timeout;
    } wait_res_t;

    function automatic logic [PHASE_WIDTH-1:0] phase_code(input phase_t ph);
        logic [PHASE_WIDTH-1:0] code;
        case (ph)
            PH_IDLE:        code = PH_CODE_IDLE;
            PH_FIRST_WAIT:  code = PH_CODE_FIRST_WAIT;
            PH_WAIT_CLEAR:  code = PH_CODE_WAIT_CLEAR;
            PH_ARMED:       code = PH_CODE_ARMED;
            PH_SECOND_WAIT: code = PH_CODE_SECOND_WAIT;
            PH_DONE:        code = PH_CODE_DONE;
            default:        code = PH_CODE_IDLE;
        endcase
        return code;
    endfunction

    // Advance the window counter; a timeout overrides a completion.
    function automatic wait_res_t wait_tick(input logic [COUNT_WIDTH-1:0]  count,
                                            input logic [WINDOW_WIDTH-1:0] window,
                                            input logic                    other);
        wait_res_t r;
        r.count   = count + COUNT_WIDTH'(1);
        r.done    = 1'b0;
        r.timeout = 1'b0;
        if ((CMP_WIDTH'(r.count) < CMP_WIDTH'(window)) && other)
        begin
            r.done  = 1'b1;
            r.count = '0;
        end
        if (CMP_WIDTH'(r.count) >= CMP_WIDTH'(window))
        begin
            r.done    = 1'b0;
            r.timeout = 1'b1;
            r.count   = '0;
        end
        return r;
    endfunction

endpackage

[design/dslc_core.sv]
// Phase tracker of the line crossing detector: state registers and per-tick rules.
// Depends on dslc_pkg.
module dslc_core
    import dslc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  logic                    sensor_a,
    input  logic                    sensor_b,
    input  logic [WINDOW_WIDTH-1:0] window_ticks,
    output result_t                 result
);

    phase_t                  phase_reg, phase_next;
    logic [MARK_WIDTH-1:0]   mark_a_reg, mark_a_next;
    logic [MARK_WIDTH-1:0]   mark_b_reg, mark_b_next;
    logic [COUNT_WIDTH-1:0]  count_reg, count_next;
    logic                    stop_reg, stop_next;

    always_comb
    begin
        wait_res_t w1;
        wait_res_t w2;
        logic      lead_a1;
        logic      lead_a2;
        phase_next  = phase_reg;
        mark_a_next = mark_a_reg;
        mark_b_next = mark_b_reg;
        count_next  = count_reg;
        stop_next   = stop_reg;
        lead_a1     = 1'b0;
        lead_a2     = 1'b0;
        w1          = '0;
        w2          = '0;

        if (phase_next == PH_IDLE)
        begin
            if (sensor_a)
            begin
                mark_a_next = MARK_FIRST;
                phase_next  = PH_FIRST_WAIT;
            end
            else if (sensor_b)
            begin
                mark_b_next = MARK_FIRST;
                phase_next  = PH_FIRST_WAIT;
            end
        end

        if (phase_next == PH_FIRST_WAIT &&
            (mark_a_next == MARK_FIRST || mark_b_next == MARK_FIRST))
        begin
            lead_a1    = (mark_a_next == MARK_FIRST);
            w1         = wait_tick(count_next, window_ticks, lead_a1 ? sensor_b : sensor_a);
            count_next = w1.count;
            if (w1.done)
                phase_next = PH_WAIT_CLEAR;
            if (w1.timeout)
            begin
                phase_next = PH_IDLE;
                if (lead_a1)
                    mark_a_next = MARK_NONE;
                else
                    mark_b_next = MARK_NONE;
            end
        end

        if (phase_next == PH_WAIT_CLEAR && !sensor_a && !sensor_b)
            phase_next = PH_ARMED;

        if (phase_next == PH_ARMED)
        begin
            if (sensor_a)
            begin
                mark_a_next = MARK_SECOND;
                phase_next  = PH_SECOND_WAIT;
            end
            else if (sensor_b)
            begin
                mark_b_next = MARK_SECOND;
                phase_next  = PH_SECOND_WAIT;
            end
        end

        if (phase_next == PH_SECOND_WAIT &&
            (mark_a_next == MARK_SECOND || mark_b_next == MARK_SECOND))
        begin
            lead_a2    = (mark_a_next == MARK_SECOND);
            w2         = wait_tick(count_next, window_ticks, lead_a2 ? sensor_b : sensor_a);
            count_next = w2.count;
            if (w2.done)
                phase_next = PH_DONE;
            if (w2.timeout)
            begin
                phase_next = PH_ARMED;
                if (lead_a2)
                    mark_a_next = MARK_FIRST;
                else
                    mark_b_next = MARK_FIRST;
            end
        end

        if (phase_next == PH_DONE)
            stop_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            mark_a_reg <= MARK_NONE;
            mark_b_reg <= MARK_NONE;
            count_reg  <= '0;
            stop_reg   <= 1'b0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            mark_a_reg <= mark_a_next;
            mark_b_reg <= mark_b_next;
            count_reg  <= count_next;
            stop_reg   <= stop_next;
        end
    end

    assign result.stop  = stop_next;
    assign result.phase = phase_code(phase_next);

endmodule

[design/dual_sensor_line_crossing_detector.sv]
// Top level of the dual sensor line crossing detector: stream ports, window
// register, input and result registers. Depends on dslc_pkg and dslc_core.
//
// Usage:
//   Each slave transaction is one sensor tick (tdata bit 0 sensor_a, bit 1
//   sensor_b). Each tick yields exactly one master transaction carrying the
//   latched stop flag (bit 0) and the phase code (bits 3:1).
//   A tick is latched into the input register, evaluated through the phase
//   rules and lands in the result register, which drives m_axis_tvalid.
//   One tick is accepted per cycle, sustained, while the receiver takes
//   results; the input and result registers both advance whenever the
//   result register is empty or being taken.
//   When the receiver stalls, the result holds, the input register fills,
//   and s_axis_tready drops; no tick is lost or dropped.
//   cfg_we writes window_ticks from cfg_wdata; write it only with no tick
//   in flight.
//   Reset clears both registers' valid flags, the phase to idle, the marks,
//   the window counter and the stop latch, and loads window_ticks with 20000.
module dual_sensor_line_crossing_detector
    import dslc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [S_DATA_WIDTH-1:0] s_axis_tdata,  // [0] sensor_a, [1] sensor_b
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [M_DATA_WIDTH-1:0] m_axis_tdata,  // [0] stop, [3:1] phase
    input  logic                    cfg_we,
    input  logic [WINDOW_WIDTH-1:0] cfg_wdata
);

    logic [WINDOW_WIDTH-1:0] window_reg;
    logic                    in_valid_reg;
    logic                    in_a_reg;
    logic                    in_b_reg;
    logic                    out_valid_reg;
    result_t                 out_reg;
    result_t                 core_result;
    logic                    advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            window_reg <= WINDOW_RESET;
        else if (cfg_we)
            window_reg <= cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            in_a_reg     <= 1'b0;
            in_b_reg     <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
            in_a_reg     <= s_axis_tdata[0];
            in_b_reg     <= s_axis_tdata[1];
        end
    end

    dslc_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .sensor_a     (in_a_reg),
        .sensor_b     (in_b_reg),
        .window_ticks (window_reg),
        .result       (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else if (!out_valid_reg || m_axis_tready)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
                out_reg <= core_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = M_DATA_WIDTH'({out_reg.phase, out_reg.stop});

    a_stop_means_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.stop) |-> (out_reg.phase == PH_CODE_DONE))
        else $error("stop reported outside the done phase");

    a_stop_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        out_reg.stop |=> out_reg.stop)
        else $error("stop latch cleared");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_axis_tready)
        else $error("input stalled with result register empty");

endmodule
